>>> rtl/core/pva_pkg.sv
`default_nettype none

package pva_pkg;

  localparam int NUM_VOICES_DEF = 8;

  localparam int NOTE_W  = 8;
  localparam int SLOT_W  = 3;
  localparam int MASK_W  = 8;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  localparam logic OP_NOTE_ON  = 1'b0;
  localparam logic OP_NOTE_OFF = 1'b1;

  typedef struct packed {
    logic load;
    logic search;
    logic apply;
  } pva_cmd_t;

  typedef struct packed {
    logic out_free;
  } pva_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/pva_ctrl.sv
`default_nettype none

module pva_ctrl
  import pva_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  output logic          s_tready,
  input  wire pva_sts_t sts,
  output pva_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SRCH  = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign s_tready   = (state == ST_IDLE);
  assign cmd.load   = s_tvalid && (state == ST_IDLE);
  assign cmd.search = (state == ST_SRCH);
  assign cmd.apply  = (state == ST_APPLY) && sts.out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_SRCH;
        end
      end
      ST_SRCH: begin
        state_next = ST_APPLY;
      end
      ST_APPLY: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_apply_after_search: assert property (@(posedge clk) disable iff (rst)
    cmd.search |=> (state == ST_APPLY))
    else $error("search not followed by apply state");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SRCH) |-> !cmd.load && !cmd.apply)
    else $error("overlapping commands during search");

  a_return_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |=> (state == ST_IDLE))
    else $error("controller did not return to idle after apply");
`endif

endmodule

`default_nettype wire

>>> rtl/core/pva_dp.sv
`default_nettype none

module pva_dp
  import pva_pkg::*;
#(
  parameter int NUM_VOICES = NUM_VOICES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire pva_cmd_t              cmd,
  output pva_sts_t                   sts,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  input  wire logic                  s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata
);

  localparam int IW = $clog2(NUM_VOICES);

  logic [NOTE_W-1:0]     slot_note [NUM_VOICES];
  logic [NUM_VOICES-1:0] slot_busy;

  logic              req_op;
  logic [NOTE_W-1:0] req_note;

  logic          free_found;
  logic [IW-1:0] free_idx;
  logic          match_found;
  logic [IW-1:0] match_idx;

  logic          free_found_next;
  logic [IW-1:0] free_idx_next;
  logic          match_found_next;
  logic [IW-1:0] match_idx_next;

  logic [NUM_VOICES-1:0] busy_next;
  logic [IW-1:0]         slot_sel;
  logic                  res_matched;
  logic                  res_stolen;
  logic [NOTE_W-1:0]     res_stolen_note;

  assign sts.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op   <= s_tuser;
      req_note <= s_tdata[NOTE_W-1:0];
    end
  end

  // priority search, lowest index wins
  always_comb begin
    free_found_next  = 1'b0;
    free_idx_next    = '0;
    match_found_next = 1'b0;
    match_idx_next   = '0;
    for (int i = NUM_VOICES - 1; i >= 0; i--) begin
      if (!slot_busy[i]) begin
        free_found_next = 1'b1;
        free_idx_next   = IW'(i);
      end
      if (slot_busy[i] && (slot_note[i] == req_note)) begin
        match_found_next = 1'b1;
        match_idx_next   = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      free_found  <= free_found_next;
      free_idx    <= free_idx_next;
      match_found <= match_found_next;
      match_idx   <= match_idx_next;
    end
  end

  always_comb begin
    busy_next       = slot_busy;
    slot_sel        = '0;
    res_matched     = 1'b0;
    res_stolen      = 1'b0;
    res_stolen_note = '0;
    if (req_op == OP_NOTE_ON) begin
      res_matched = 1'b1;
      if (free_found) begin
        slot_sel            = free_idx;
        busy_next[free_idx] = 1'b1;
      end else begin
        slot_sel        = IW'(NUM_VOICES - 1);
        res_stolen      = 1'b1;
        res_stolen_note = slot_note[0];
        busy_next       = {1'b1, slot_busy[NUM_VOICES-1:1]};
      end
    end else if (match_found) begin
      slot_sel             = match_idx;
      res_matched          = 1'b1;
      busy_next[match_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_busy <= '0;
    end else if (cmd.apply) begin
      slot_busy <= busy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply && (req_op == OP_NOTE_ON)) begin
      if (free_found) begin
        slot_note[free_idx] <= req_note;
      end else begin
        for (int i = 0; i < NUM_VOICES - 1; i++) begin
          slot_note[i] <= slot_note[i+1];
        end
        slot_note[NUM_VOICES-1] <= req_note;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.apply) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      m_tdata <= {3'b000, MASK_W'(busy_next), res_stolen_note, res_stolen, res_matched,
                  SLOT_W'(slot_sel)};
    end
  end

`ifndef SYNTHESIS
  a_apply_loads_out: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |=> m_tvalid)
    else $error("result not presented after apply");

  a_note_on_matched: assert property (@(posedge clk) disable iff (rst)
    (cmd.apply && (req_op == OP_NOTE_ON)) |=> m_tdata[3])
    else $error("note-on result without matched flag");

  a_steal_only_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.apply && res_stolen) |-> (&slot_busy))
    else $error("steal while a slot was free");

  a_apply_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |-> (!m_tvalid || m_tready))
    else $error("result overwritten before it was taken");
`endif

endmodule

`default_nettype wire

>>> rtl/core/poly_voice_allocator.sv
`default_nettype none

// Polyphonic voice allocator. A note-on request takes the lowest free voice slot; when
// every slot is busy, the note in slot 0 is dropped, all slots move down by one and the
// new note goes into the last slot. A note-off frees the lowest busy slot holding that
// note. Each request gives one result with slot, matched, stolen, stolen_note and the
// busy mask after the event. The controller first takes a request in, then runs the
// priority search across the slot table, and then updates the table and loads the output
// register; that last step waits while the output register still holds an untaken
// result. The busy flags clear on reset, no clearing pass is needed.
module poly_voice_allocator
  import pva_pkg::*;
#(
  parameter int NUM_VOICES = NUM_VOICES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // note[7:0]
  input  wire logic                  s_tuser,   // op[0]
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // slot[2:0], matched[3], stolen[4], stolen_note[12:5], busy_mask[20:13], zero[23:21]
  output logic [OUT_DATA_W-1:0]      m_tdata
);

  pva_cmd_t cmd;
  pva_sts_t sts;

  pva_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pva_dp #(
    .NUM_VOICES (NUM_VOICES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

>>> verif/tb.sv
module tb
  import pva_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV = NUM_VOICES_DEF;
  localparam int RANDOM_EVENTS = 726;

  typedef struct packed {
    logic             op;
    logic [NOTE_W-1:0] note;
  } note_event_t;

  typedef struct packed {
    logic [2:0]        pad;
    logic [MASK_W-1:0] busy_mask;
    logic [NOTE_W-1:0] stolen_note;
    logic              stolen;
    logic              matched;
    logic [SLOT_W-1:0] slot;
  } voice_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  note_event_t   pending_events[$];
  voice_result_t expected_results[$];
  logic [NOTE_W-1:0] voice_note[NV];
  logic              voice_busy[NV];
  int events_total = 0;
  int events_sent = 0;
  int fail_count = 0;

  poly_voice_allocator u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // voice table update for one request, returns the result it gives
  function automatic voice_result_t apply_event(note_event_t ev);
    voice_result_t r;
    int hit;
    int i;
    r = '0;
    hit = -1;
    if (ev.op == OP_NOTE_ON) begin
      for (i = 0; i < NV; i++) begin
        if (!voice_busy[i] && hit < 0) hit = i;
      end
      if (hit < 0) begin
        r.stolen = 1'b1;
        r.stolen_note = voice_note[0];
        for (i = 1; i < NV; i++) begin
          voice_note[i-1] = voice_note[i];
          voice_busy[i-1] = voice_busy[i];
        end
        hit = NV - 1;
      end
      voice_note[hit] = ev.note;
      voice_busy[hit] = 1'b1;
      r.slot = SLOT_W'(hit);
      r.matched = 1'b1;
    end else begin
      for (i = 0; i < NV; i++) begin
        if (hit < 0 && voice_busy[i] && voice_note[i] == ev.note) begin
          voice_busy[i] = 1'b0;
          r.slot = SLOT_W'(i);
          r.matched = 1'b1;
          hit = i;
        end
      end
    end
    for (i = 0; i < NV && i < MASK_W; i++) r.busy_mask[i] = voice_busy[i];
    return r;
  endfunction

  // mostly short gaps, a few long ones, and now and then a run with none
  function automatic int draw_idle(inout int calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // driver
  int tx_gap = 0;
  int tx_calm = 0;
  always @(posedge clk) begin
    note_event_t ev;
    logic nxt_valid;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !s_tready)) begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(apply_event({s_tuser, s_tdata}));
        events_sent++;
      end
      nxt_valid = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (pending_events.size() > 0) begin
        ev = pending_events.pop_front();
        s_tdata <= ev.note;
        s_tuser <= ev.op;
        nxt_valid = 1'b1;
        tx_gap = draw_idle(tx_calm);
      end
      s_tvalid <= nxt_valid;
    end
  end

  // monitor
  int rx_hold = 0;
  int rx_calm = 0;
  always @(posedge clk) begin
    voice_result_t exp_r;
    voice_result_t got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %h", m_tdata);
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            fail_count++;
            if (fail_count <= 10) begin
              $write("mismatch: expected slot=%0d matched=%b stolen=%b stolen_note=%02h ",
                     exp_r.slot, exp_r.matched, exp_r.stolen, exp_r.stolen_note);
              $write("busy=%02h pad=%0d, ", exp_r.busy_mask, exp_r.pad);
              $write("got slot=%0d matched=%b stolen=%b ",
                     got.slot, got.matched, got.stolen);
              $display("stolen_note=%02h busy=%02h pad=%0d",
                       got.stolen_note, got.busy_mask, got.pad);
            end
          end
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 9) == 0) rx_hold = draw_idle(rx_calm);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [NOTE_W-1:0] held[$];
    logic [NOTE_W-1:0] pool[8];
    logic [NOTE_W-1:0] n;
    int k;
    int pick;
    int on_pct;

    for (k = 0; k < NV; k++) begin
      voice_note[k] = '0;
      voice_busy[k] = 1'b0;
    end

    // empty table, fill, steal twice, duplicate release, stale note, drain
    pending_events.push_back({OP_NOTE_OFF, 8'h00});
    pending_events.push_back({OP_NOTE_ON,  8'h00});
    pending_events.push_back({OP_NOTE_ON,  8'hFF});
    pending_events.push_back({OP_NOTE_ON,  8'h55});
    pending_events.push_back({OP_NOTE_ON,  8'hAA});
    pending_events.push_back({OP_NOTE_ON,  8'h3C});
    pending_events.push_back({OP_NOTE_ON,  8'h3C});
    pending_events.push_back({OP_NOTE_ON,  8'h01});
    pending_events.push_back({OP_NOTE_ON,  8'h80});
    pending_events.push_back({OP_NOTE_ON,  8'h7F});
    pending_events.push_back({OP_NOTE_ON,  8'hFE});
    pending_events.push_back({OP_NOTE_OFF, 8'h3C});
    pending_events.push_back({OP_NOTE_OFF, 8'h3C});
    pending_events.push_back({OP_NOTE_OFF, 8'h3C});
    pending_events.push_back({OP_NOTE_OFF, 8'h55});
    pending_events.push_back({OP_NOTE_OFF, 8'h55});
    pending_events.push_back({OP_NOTE_ON,  8'h12});
    pending_events.push_back({OP_NOTE_OFF, 8'hFF});
    pending_events.push_back({OP_NOTE_OFF, 8'h7F});
    pending_events.push_back({OP_NOTE_OFF, 8'hFE});
    pending_events.push_back({OP_NOTE_OFF, 8'h80});
    pending_events.push_back({OP_NOTE_OFF, 8'hAA});
    pending_events.push_back({OP_NOTE_OFF, 8'h01});
    pending_events.push_back({OP_NOTE_OFF, 8'h12});

    for (k = 0; k < 8; k++) pool[k] = 8'($urandom);

    // key presses and releases that track held notes, with stray releases mixed in
    for (k = 0; k < RANDOM_EVENTS; k++) begin
      if (held.size() < 3) on_pct = 85;
      else if (held.size() > 11) on_pct = 20;
      else on_pct = 50;
      if ($urandom_range(0, 99) < on_pct) begin
        if ($urandom_range(0, 9) < 3) n = pool[$urandom_range(0, 7)];
        else n = 8'($urandom_range(0, 255));
        held.push_back(n);
        pending_events.push_back({OP_NOTE_ON, n});
      end else if (held.size() > 0 && $urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, held.size() - 1);
        n = held[pick];
        held.delete(pick);
        pending_events.push_back({OP_NOTE_OFF, n});
      end else begin
        pending_events.push_back({OP_NOTE_OFF, 8'($urandom_range(0, 255))});
      end
    end
    events_total = pending_events.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (events_sent < events_total || expected_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
